### src/qts_pkg.sv
// Shared widths, register indexes and reset values for the quintic trajectory sampler.
package qts_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int T_W = 24;
  localparam int POS_W = 32;
  localparam int W_W = 64;
  localparam int S_W = 56;
  localparam int DIV_STEP = 4;
  localparam int MAC_LAT = 5;
  localparam int HORNER_STEPS = 5;
  localparam int LOW_STEPS = 2;
  localparam int FRAC_S = 32;
  localparam int FRAC_A = 17;
  localparam int FRAC_V = 16;

  typedef logic signed [W_W-1:0] wide_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [T_W-1:0] time_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_START_POSITION = 3'd0;
  localparam cfg_idx_t REG_START_VELOCITY = 3'd1;
  localparam cfg_idx_t REG_START_ACCELERATION = 3'd2;
  localparam cfg_idx_t REG_END_POSITION = 3'd3;
  localparam cfg_idx_t REG_END_VELOCITY = 3'd4;
  localparam cfg_idx_t REG_END_ACCELERATION = 3'd5;
  localparam cfg_idx_t REG_DURATION = 3'd6;

  localparam pos_t RST_END_POSITION = 32'sd65536;
  localparam time_t RST_DURATION = 24'd131072;

  localparam wide_t WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t WIDE_MIN = 64'sh8000_0000_0000_0000;

endpackage

### src/qts_coef.sv
// Pipelined solve of the cubic, quartic and quintic coefficients from the boundary registers.
module qts_coef (
  input  logic           clk,
  input  qts_pkg::pos_t  p0,
  input  qts_pkg::pos_t  v0,
  input  qts_pkg::pos_t  a0,
  input  qts_pkg::pos_t  p1,
  input  qts_pkg::pos_t  v1,
  input  qts_pkg::pos_t  a1,
  input  qts_pkg::time_t dur,
  output qts_pkg::wide_t c3,
  output qts_pkg::wide_t c4,
  output qts_pkg::wide_t c5
);
  import qts_pkg::*;

  logic [2*T_W-1:0] tsq;
  logic signed [56:0] vt;
  logic signed [56:0] at;
  logic signed [32:0] dp;
  logic signed [32:0] dvv;
  logic signed [32:0] da1;
  logic signed [32:0] da2;
  logic signed [31:0] a0_1;
  time_t dur1;
  time_t dur2;

  logic [31:0] t2_2;
  logic signed [64:0] at2;
  wide_t hp;
  wide_t dv;

  wide_t h;
  wide_t dvt;
  wide_t dat2;
  wide_t dat2h;
  logic signed [65:0] dv_prod;
  logic signed [65:0] da_prod;

  assign dv_prod = $signed(dv[40:0]) * $signed({1'b0, dur2});
  assign da_prod = da2 * $signed({1'b0, t2_2});

  always_ff @(posedge clk) begin
    tsq <= dur * dur;
    vt <= v0 * $signed({1'b0, dur});
    at <= a0 * $signed({1'b0, dur});
    dp <= 33'(p1) - 33'(p0);
    dvv <= 33'(v1) - 33'(v0);
    da1 <= 33'(a1) - 33'(a0);
    a0_1 <= a0;
    dur1 <= dur;

    at2 <= a0_1 * $signed({1'b0, tsq[2*T_W-1:16]});
    hp <= 64'(dp) - 64'(vt >>> FRAC_V);
    dv <= 64'(dvv) - 64'(at >>> FRAC_V);
    da2 <= da1;
    dur2 <= dur1;
    t2_2 <= tsq[2*T_W-1:16];

    h <= hp - 64'(at2 >>> FRAC_A);
    dvt <= 64'(dv_prod >>> FRAC_V);
    dat2 <= 64'(da_prod >>> FRAC_V);
    dat2h <= 64'(da_prod >>> FRAC_A);

    c3 <= h * 64'sd10 - dvt * 64'sd4 + dat2h;
    c4 <= dvt * 64'sd7 - h * 64'sd15 - dat2;
    c5 <= h * 64'sd6 - dvt * 64'sd3 + dat2h;
  end

endmodule

### src/qts_div.sv
// Pipelined restoring divider forming normalized time s = t * 2^32 / T.
module qts_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  qts_pkg::time_t          t,
  input  qts_pkg::time_t          dur,
  output logic                    out_valid,
  output logic [qts_pkg::S_W-1:0] s,
  output qts_pkg::time_t          t_out
);
  import qts_pkg::*;

  localparam int NSTG = S_W / DIV_STEP;

  logic [NSTG-1:0] vld;
  logic [T_W-1:0]  rem_q [NSTG];
  logic [S_W-1:0]  quo_q [NSTG];
  time_t           t_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic           v_p;
    logic [T_W-1:0] rem_p;
    logic [T_W-1:0] rem_n;
    logic [S_W-1:0] quo_p;
    logic [S_W-1:0] quo_n;
    time_t          t_p;
    logic [T_W:0]   trial;
    logic [S_W-1:0] dvd;

    if (k == 0) begin : g_first
      assign v_p = in_valid;
      assign rem_p = '0;
      assign quo_p = '0;
      assign t_p = t;
    end else begin : g_next
      assign v_p = vld[k-1];
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
      assign t_p = t_q[k-1];
    end

    always_comb begin
      rem_n = rem_p;
      quo_n = quo_p;
      trial = '0;
      dvd = {t_p, {(S_W-T_W){1'b0}}};
      for (int j = 0; j < DIV_STEP; j++) begin
        trial = {rem_n, dvd[S_W-1-k*DIV_STEP-j]};
        if (trial >= {1'b0, dur}) begin
          rem_n = T_W'(trial - {1'b0, dur});
          quo_n = {quo_n[S_W-2:0], 1'b1};
        end else begin
          rem_n = trial[T_W-1:0];
          quo_n = {quo_n[S_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_n;
        quo_q[k] <= quo_n;
        t_q[k] <= t_p;
      end
    end
  end

  assign out_valid = vld[NSTG-1];
  assign s = quo_q[NSTG-1];
  assign t_out = t_q[NSTG-1];

endmodule

### src/qts_mac.sv
// Pipelined saturating multiply, floor rescale and saturating add of one Horner step.
module qts_mac #(
  parameter int SH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  qts_pkg::wide_t a,
  input  logic [63:0]    b,
  input  logic [63:0]    side,
  input  qts_pkg::wide_t addend,
  output logic           out_valid,
  output qts_pkg::wide_t y,
  output logic [63:0]    side_out
);
  import qts_pkg::*;

  logic [MAC_LAT-1:0] vld;
  logic [63:0]        side_q [MAC_LAT];

  logic [63:0]         p_ll;
  logic [63:0]         p_lh;
  logic signed [64:0]  p_hl;
  logic signed [64:0]  p_hh;
  logic [127:0]        sa;
  logic [127:0]        sb;
  logic [127:0]        sum;
  wide_t               y4;
  logic                ovf;
  logic signed [64:0]  s65;

  assign ovf = sum[127:SH+63] != {(65-SH){sum[127]}};
  assign s65 = {y4[63], y4} + {addend[63], addend};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[MAC_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side;
      for (int k = 1; k < MAC_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
      p_ll <= a[31:0] * b[31:0];
      p_lh <= a[31:0] * b[63:32];
      p_hl <= $signed(a[63:32]) * $signed({1'b0, b[31:0]});
      p_hh <= $signed(a[63:32]) * $signed({1'b0, b[63:32]});
      sa <= {64'd0, p_ll} + {32'd0, p_lh, 32'd0};
      sb <= {{31{p_hl[64]}}, p_hl, 32'd0} + {p_hh[63:0], 64'd0};
      sum <= sa + sb;
      if (ovf) begin
        y4 <= sum[127] ? WIDE_MIN : WIDE_MAX;
      end else begin
        y4 <= sum[SH+63:SH];
      end
      if (s65[64] != s65[63]) begin
        y <= s65[64] ? WIDE_MIN : WIDE_MAX;
      end else begin
        y <= s65[63:0];
      end
    end
  end

  assign out_valid = vld[MAC_LAT-1];
  assign side_out = side_q[MAC_LAT-1];

endmodule

### src/quintic_trajectory_sampler.sv
// Top level of the quintic trajectory sampler: registers, evaluation pipeline, output queue.
// Takes one sample time per cycle while the output queue is not full and returns the
// trajectory position through the normalized-time divider, five Horner multiply-add stages,
// the final sum register and the two-beat output queue. The coefficients are rebuilt from
// the registers through the coefficient pipeline after any write, which is well inside the
// time an item needs to reach them, so samples may follow a register write at once.
// The input stalls only when the output queue is full.
module quintic_trajectory_sampler (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  qts_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  qts_pkg::time_t    sample_time,
  output logic              out_valid,
  input  logic              out_stall,
  output qts_pkg::pos_t     position
);
  import qts_pkg::*;

  localparam int DLY = (HORNER_STEPS - LOW_STEPS) * MAC_LAT;

  pos_t  p0;
  pos_t  v0;
  pos_t  a0;
  pos_t  p1;
  pos_t  v1;
  pos_t  a1;
  time_t dur;
  time_t dur_eff;

  wide_t c3;
  wide_t c4;
  wide_t c5;

  logic           en;
  logic           div_valid;
  logic [S_W-1:0] div_s;
  time_t          div_t;

  logic        hv [HORNER_STEPS+1];
  wide_t       hr [HORNER_STEPS+1];
  logic [63:0] hs [HORNER_STEPS+1];

  wide_t       low1;
  logic [63:0] low1_t;
  logic        low1_valid;
  wide_t       low2;
  wide_t       bp_dly [DLY];

  logic               fin_valid;
  pos_t               fin;
  logic signed [64:0] s65;

  pos_t       fifo_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0 <= '0;
      v0 <= '0;
      a0 <= '0;
      p1 <= RST_END_POSITION;
      v1 <= '0;
      a1 <= '0;
      dur <= RST_DURATION;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_POSITION:     p0 <= cfg_data;
        REG_START_VELOCITY:     v0 <= cfg_data;
        REG_START_ACCELERATION: a0 <= cfg_data;
        REG_END_POSITION:       p1 <= cfg_data;
        REG_END_VELOCITY:       v1 <= cfg_data;
        REG_END_ACCELERATION:   a1 <= cfg_data;
        REG_DURATION:           dur <= cfg_data[T_W-1:0];
        default: ;
      endcase
    end
  end

  assign dur_eff = (dur == '0) ? time_t'(1) : dur;

  qts_coef u_coef (
    .clk (clk),
    .p0  (p0),
    .v0  (v0),
    .a0  (a0),
    .p1  (p1),
    .v1  (v1),
    .a1  (a1),
    .dur (dur_eff),
    .c3  (c3),
    .c4  (c4),
    .c5  (c5)
  );

  assign en = (count != 2'd2);
  assign in_stall = ~en;

  qts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .t         (sample_time),
    .dur       (dur_eff),
    .out_valid (div_valid),
    .s         (div_s),
    .t_out     (div_t)
  );

  assign hv[0] = div_valid;
  assign hr[0] = c5;
  assign hs[0] = {{(64-S_W){1'b0}}, div_s};

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    wide_t addend;
    if (k == 0) begin : g_c4
      assign addend = c4;
    end else if (k == 1) begin : g_c3
      assign addend = c3;
    end else begin : g_zero
      assign addend = '0;
    end

    qts_mac #(.SH(FRAC_S)) u_mac (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (hv[k]),
      .a         (hr[k]),
      .b         (hs[k]),
      .side      (hs[k]),
      .addend    (addend),
      .out_valid (hv[k+1]),
      .y         (hr[k+1]),
      .side_out  (hs[k+1])
    );
  end

  qts_mac #(.SH(FRAC_A)) u_low_acc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .a         (64'(a0)),
    .b         ({{(64-T_W){1'b0}}, div_t}),
    .side      ({{(64-T_W){1'b0}}, div_t}),
    .addend    (64'(v0)),
    .out_valid (low1_valid),
    .y         (low1),
    .side_out  (low1_t)
  );

  qts_mac #(.SH(FRAC_V)) u_low_vel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (low1_valid),
    .a         (low1),
    .b         (low1_t),
    .side      (low1_t),
    .addend    (64'(p0)),
    .out_valid (),
    .y         (low2),
    .side_out  ()
  );

  always_ff @(posedge clk) begin
    if (en) begin
      bp_dly[0] <= low2;
      for (int k = 1; k < DLY; k++) begin
        bp_dly[k] <= bp_dly[k-1];
      end
    end
  end

  assign s65 = {bp_dly[DLY-1][63], bp_dly[DLY-1]} + {hr[HORNER_STEPS][63], hr[HORNER_STEPS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= hv[HORNER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s65 > 65'sd2147483647) begin
        fin <= 32'sh7FFF_FFFF;
      end else if (s65 < -65'sd2147483648) begin
        fin <= 32'sh8000_0000;
      end else begin
        fin <= s65[31:0];
      end
    end
  end

  assign push = en & fin_valid;
  assign pop = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_data[wr_ptr] <= fin;
    end
  end

  assign out_valid = (count != 2'd0);
  assign position = fifo_data[rd_ptr];

endmodule
